// ===== rtl/core/positional_list_buffer_defines.svh =====
// assertion macros for the positional list buffer
// used by the top level only, expects clk and rst in scope
`ifndef POSITIONAL_LIST_BUFFER_DEFINES_SVH
`define POSITIONAL_LIST_BUFFER_DEFINES_SVH

// same-cycle implication
`define PLB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list buffer check failed");

// next-cycle implication
`define PLB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list buffer check failed");

`endif

// ===== rtl/core/plb_pkg.sv =====
// shared types and codes for the positional list buffer
// no dependencies
`timescale 1ns / 1ps

package plb_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } plb_state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

// ===== rtl/core/plb_cell.sv =====
// one storage cell of the list: holds a single entry and one stage of the read chain
// depends on plb_pkg
`timescale 1ns / 1ps

module plb_cell
  import plb_pkg::*;
#(
  parameter int IDX = 0,
  parameter int EW  = 32
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [EW-1:0] ins_value,
  input  logic [EW-1:0] prev_entry,
  input  logic [EW-1:0] next_entry,
  input  logic [EW-1:0] rd_in,
  output logic [EW-1:0] entry,
  output logic [EW-1:0] rd_out
);

  localparam logic [31:0] IDX_L = 32'(IDX);

  logic [31:0] pos_ext;
  logic        at_pos;
  logic        above_pos;

  assign pos_ext   = 32'(cmd.pos);
  assign at_pos    = (IDX_L == pos_ext);
  assign above_pos = (IDX_L > pos_ext);

  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      if (above_pos) begin
        entry <= prev_entry;
      end else if (at_pos) begin
        entry <= ins_value;
      end
    end else if (cmd.shift_down && (above_pos || at_pos)) begin
      entry <= next_entry;
    end
  end

  // the selected entry moves one cell towards cell zero per cycle
  always_ff @(posedge clk) begin
    rd_out <= at_pos ? entry : rd_in;
  end

endmodule

// ===== rtl/core/positional_list_buffer.sv =====
// top level of the positional list buffer: control, count, register port, cell row
// depends on plb_pkg, plb_cell and positional_list_buffer_defines.svh
`timescale 1ns / 1ps
`include "positional_list_buffer_defines.svh"

// Ordered list held in a row of DEPTH cells, one entry per cell. Insert shifts
// every later entry up by one cell and delete shifts them down. Insert, clear
// and any rejected action load the output register straight from idle. Get
// and delete read through a chain that carries the selected entry one cell per
// cycle towards cell zero, and the result is taken when it reaches cell zero.
// The result sits in an output register; the next item is taken while that
// register is empty or being emptied and no get or delete is walking. capacity
// lives at byte address 0 of the register port and is clipped to DEPTH.
module positional_list_buffer
  import plb_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] action,
  input  logic [POS_W-1:0]    position,
  input  logic [VALUE_W-1:0]  entry_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  read_value,
  output logic [COUNT_W-1:0]  entry_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [BW-1:0] DEPTH_L = BW'(DEPTH);

  plb_state_t           state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CAP_W-1:0]     capacity;
  logic [POS_W-1:0]     walk_cnt, walk_cnt_next;
  logic [POS_W-1:0]     pos_q, pos_q_next;
  logic [ACTION_W-1:0]  act_q, act_q_next;

  logic                 in_fire;
  logic                 load_out;
  logic [STATUS_W-1:0]  status_next;
  logic [VALUE_W-1:0]   read_value_next;

  logic [BW-1:0]        count_ext, pos_ext, cap_ext, bound;
  logic                 full, in_range;
  logic [POS_W-1:0]     eff_pos;
  logic [ENTRY_WIDTH-1:0] ins_value;

  cell_cmd_t            cmd;
  logic [ENTRY_WIDTH-1:0] cell_entry [DEPTH];
  logic [ENTRY_WIDTH-1:0] cell_rd    [DEPTH+1];

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_CAPACITY) ? 32'(capacity) : 32'd0;

  // decode of the incoming item
  assign count_ext = BW'(count);
  assign pos_ext   = BW'(position);
  assign cap_ext   = BW'(capacity);
  assign bound     = (cap_ext < DEPTH_L) ? cap_ext : DEPTH_L;
  assign full      = (count_ext >= bound);
  assign in_range  = (pos_ext < count_ext);
  assign eff_pos   = (pos_ext > count_ext) ? POS_W'(count) : position;
  assign ins_value = ENTRY_WIDTH'(entry_value);

  assign in_stall = (state == S_WALK) || (out_valid && out_stall);
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      walk_cnt <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      walk_cnt <= walk_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pos_q <= pos_q_next;
    act_q <= act_q_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    walk_cnt_next   = walk_cnt;
    pos_q_next      = pos_q;
    act_q_next      = act_q;
    load_out        = 1'b0;
    status_next     = STAT_OK;
    read_value_next = '0;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        cmd.pos = eff_pos;
        if (in_fire) begin
          pos_q_next = position;
          act_q_next = action;
          case (action)
            ACT_INSERT: begin
              load_out = 1'b1;
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                cmd.shift_up = 1'b1;
                count_next   = count + CW'(1);
              end
            end
            ACT_GET, ACT_DELETE: begin
              if (in_range) begin
                state_next    = S_WALK;
                walk_cnt_next = '0;
              end else begin
                load_out    = 1'b1;
                status_next = STAT_RANGE;
              end
            end
            default: begin
              load_out   = 1'b1;
              count_next = '0;
            end
          endcase
        end
      end
      S_WALK: begin
        cmd.pos       = pos_q;
        walk_cnt_next = walk_cnt + POS_W'(1);
        // selected entry has reached cell zero
        if (walk_cnt == pos_q) begin
          load_out        = 1'b1;
          read_value_next = VALUE_W'(cell_rd[0]);
          state_next      = S_IDLE;
          if (act_q == ACT_DELETE) begin
            cmd.shift_down = 1'b1;
            count_next     = count - CW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= status_next;
      read_value  <= read_value_next;
      entry_count <= COUNT_W'(count_next);
    end
  end

  // cell row
  assign cell_rd[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] prev_entry;
    logic [ENTRY_WIDTH-1:0] next_entry;

    if (i == 0) begin : g_first
      assign prev_entry = ins_value;
    end else begin : g_prev
      assign prev_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = cell_entry[i];
    end else begin : g_next
      assign next_entry = cell_entry[i+1];
    end

    plb_cell #(
      .IDX (i),
      .EW  (ENTRY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .ins_value  (ins_value),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .rd_in      (cell_rd[i+1]),
      .entry      (cell_entry[i]),
      .rd_out     (cell_rd[i])
    );
  end

  // checks
  `PLB_ASSERT_NOW(a_count_bound, 1'b1, count_ext <= DEPTH_L)
  `PLB_ASSERT_NOW(a_walk_no_result, state == S_WALK, !out_valid && walk_cnt <= pos_q)
  `PLB_ASSERT_NEXT(a_insert_grows, in_fire && action == ACT_INSERT && !full, count == $past(count) + CW'(1))
  `PLB_ASSERT_NEXT(a_clear_empties, in_fire && action == ACT_CLEAR, count == '0 && out_valid)

endmodule
